[rtl/hsse_pkg.sv]
// shared types and constants for the hashed scalar sparse encoder
// no dependencies
`default_nettype none
package hsse_pkg;
	localparam int unsigned MaxActiveDef = 64;
	localparam int unsigned MaxSizeDef   = 65536;
	localparam logic [31:0] ResReset     = 32'd65536;
	localparam logic [6:0]  ActReset     = 7'd1;
	localparam logic [16:0] SizeReset    = 17'd1024;
	localparam logic [31:0] SeedReset    = 32'd0;
	localparam logic [1:0]  RegRes  = 2'd0;
	localparam logic [1:0]  RegAct  = 2'd1;
	localparam logic [1:0]  RegSize = 2'd2;
	localparam logic [1:0]  RegSeed = 2'd3;
	localparam logic [31:0] MurC1 = 32'hcc9e2d51;
	localparam logic [31:0] MurC2 = 32'h1b873593;
	localparam logic [31:0] MurN  = 32'he6546b64;
	localparam logic [31:0] MurF1 = 32'h85ebca6b;
	localparam logic [31:0] MurF2 = 32'hc2b2ae35;

	// datapath operations, one per controller step
	typedef enum logic [3:0] {
		OP_NONE, OP_DIV_START, OP_DIV_STEP, OP_DIV_END,
		OP_SEED_LOAD, OP_IDX_LOAD, OP_HASH_STEP, OP_SEED_SAVE,
		OP_MOD_START, OP_MOD_STEP
	} hsse_op_t;
endpackage
`default_nettype wire

[rtl/hsse_if.sv]
// valid/ready channel interfaces for input samples and output positions
// depends on nothing
`default_nettype none
interface hsse_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] sample;
	logic no_value;
	modport source (output valid, sample, no_value, input ready);
	modport sink (input valid, sample, no_value, output ready);
endinterface

interface hsse_out_if;
	logic valid;
	logic ready;
	logic [15:0] bit_position;
	logic position_valid;
	logic last_position;
	modport source (output valid, bit_position, position_valid, last_position, input ready);
	modport sink (input valid, bit_position, position_valid, last_position, output ready);
endinterface
`default_nettype wire

[rtl/hsse_datapath.sv]
// datapath: restoring divider, murmur hash unit with one multiply per step,
// and restoring modulo unit; depends on hsse_pkg
`default_nettype none
module hsse_datapath
	import hsse_pkg::*;
(
	input  wire logic        clk,
	input  wire hsse_op_t    op,
	input  wire logic [2:0]  hstep,
	input  wire logic [31:0] sample,
	input  wire logic [31:0] resolution,
	input  wire logic [16:0] size,
	input  wire logic [31:0] seed_in,
	input  wire logic [5:0]  offset,
	output logic      [15:0] position
);
	logic [31:0] quo_q, rem_q, den_q, idx_q, h_q, k_q, dseed_q, mod_q;
	logic        neg_q;
	logic [32:0] trial;
	logic [31:0] mag;
	logic [31:0] mul_a, mul_b, prod;
	logic [32:0] mtrial;

	assign mag = sample[31] ? (~sample + 32'd1) : sample;
	assign trial = {rem_q, quo_q[31]} - {1'b0, den_q};
	assign mtrial = {mod_q[31:0], h_q[31]} - {16'd0, size};

	// one 32x32 low multiply per hash step
	always_comb begin
		mul_a = k_q;
		mul_b = MurC1;
		case (hstep)
			3'd0: begin mul_a = k_q; mul_b = MurC1; end
			3'd1: begin mul_a = {k_q[16:0], k_q[31:17]}; mul_b = MurC2; end
			3'd2: begin mul_a = h_q; mul_b = 32'd5; end
			3'd3: begin mul_a = h_q ^ {16'd0, h_q[31:16]}; mul_b = MurF1; end
			3'd4: begin mul_a = h_q ^ {13'd0, h_q[31:13]}; mul_b = MurF2; end
			default: begin mul_a = k_q; mul_b = MurC1; end
		endcase
	end
	assign prod = mul_a * mul_b;

	// mix the finished key word into the hash state
	logic [31:0] hx;
	assign hx = h_q ^ prod;

	always_ff @(posedge clk) begin
		case (op)
			OP_DIV_START: begin
				quo_q <= mag;
				rem_q <= 32'd0;
				den_q <= (resolution == 32'd0) ? 32'd1 : resolution;
				neg_q <= sample[31];
			end
			OP_DIV_STEP: begin
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[30:0], quo_q[31]};
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
			OP_DIV_END: idx_q <= neg_q ? (~quo_q + 32'd1) : quo_q;
			OP_SEED_LOAD: begin
				k_q <= seed_in;
				h_q <= 32'd0;
			end
			OP_IDX_LOAD: begin
				k_q <= idx_q + {26'd0, offset};
				h_q <= dseed_q;
			end
			OP_HASH_STEP: begin
				case (hstep)
					3'd0: k_q <= prod;
					3'd1: begin
						k_q <= prod;
						h_q <= {hx[18:0], hx[31:19]};
					end
					3'd2: h_q <= (prod + MurN) ^ 32'd4;
					3'd3: h_q <= prod;
					3'd4: h_q <= prod;
					3'd5: h_q <= h_q ^ {16'd0, h_q[31:16]};
					default: ;
				endcase
			end
			OP_SEED_SAVE: dseed_q <= h_q;
			OP_MOD_START: mod_q <= 32'd0;
			OP_MOD_STEP: begin
				if (!mtrial[32]) mod_q <= mtrial[31:0];
				else mod_q <= {mod_q[30:0], h_q[31]};
				h_q <= {h_q[30:0], 1'b0};
			end
			default: ;
		endcase
	end
	assign position = mod_q[15:0];
endmodule
`default_nettype wire

[rtl/hsse_ctrl.sv]
// controller state machine sequencing division, hashing and modulo
// depends on hsse_pkg
`default_nettype none
module hsse_ctrl
	import hsse_pkg::*;
#(
	parameter int unsigned MAX_ACTIVE = MaxActiveDef
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_no_value,
	output logic            in_ready,
	input  wire logic       out_ready,
	output logic            out_valid,
	output logic            out_pvalid,
	output logic            out_last,
	input  wire logic [6:0] active_bits,
	output hsse_op_t        op,
	output logic [2:0]      hstep,
	output logic [5:0]      offset
);
	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_DIVEND, S_SEED, S_SAVE, S_LOAD, S_HASH, S_MODST, S_MOD, S_OUT
	} state_t;
	state_t state_q;
	logic [5:0] cnt_q;
	logic [6:0] k_q, count;
	logic [2:0] hs_q;
	logic pv_q, last_q;

	always_comb begin
		count = active_bits;
		if (count == 7'd0) count = 7'd1;
		if (count > 7'(MAX_ACTIVE)) count = 7'(MAX_ACTIVE);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_pvalid = pv_q;
	assign out_last  = last_q;
	assign hstep = hs_q;
	assign offset = k_q[5:0];

	always_comb begin
		case (state_q)
			S_IDLE:   op = (in_valid && !in_no_value) ? OP_DIV_START : OP_NONE;
			S_DIV:    op = OP_DIV_STEP;
			S_DIVEND: op = OP_DIV_END;
			S_SEED:   op = OP_SEED_LOAD;
			S_SAVE:   op = OP_SEED_SAVE;
			S_LOAD:   op = OP_IDX_LOAD;
			S_HASH:   op = OP_HASH_STEP;
			S_MODST:  op = OP_MOD_START;
			S_MOD:    op = OP_MOD_STEP;
			default:  op = OP_NONE;
		endcase
	end

	logic seed_done_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; cnt_q <= '0; k_q <= '0; hs_q <= '0;
			pv_q <= 1'b0; last_q <= 1'b0; seed_done_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					if (in_no_value) begin
						pv_q <= 1'b0; last_q <= 1'b1; state_q <= S_OUT;
					end else begin
						cnt_q <= '0; state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) state_q <= S_DIVEND;
				end
				S_DIVEND: begin state_q <= S_SEED; seed_done_q <= 1'b0; end
				S_SEED: begin hs_q <= '0; state_q <= S_HASH; end
				S_HASH: begin
					hs_q <= hs_q + 3'd1;
					if (hs_q == 3'd5) begin
						if (!seed_done_q) state_q <= S_SAVE;
						else state_q <= S_MODST;
					end
				end
				S_SAVE: begin seed_done_q <= 1'b1; k_q <= '0; state_q <= S_LOAD; end
				S_LOAD: begin hs_q <= '0; state_q <= S_HASH; end
				S_MODST: begin cnt_q <= '0; state_q <= S_MOD; end
				S_MOD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						pv_q <= 1'b1;
						last_q <= (k_q + 7'd1 == count);
						state_q <= S_OUT;
					end
				end
				S_OUT: if (out_ready) begin
					if (last_q || !pv_q) state_q <= S_IDLE;
					else begin k_q <= k_q + 7'd1; state_q <= S_LOAD; end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/hashed_scalar_sparse_encoder.sv]
// hashed scalar sparse encoder: after the divide and the seed hash, each position is made by
// a load, 6 hash steps, a 32-step modulo and an output transaction
// the restoring divider and the seed hash run once per sample
// one sample at a time: the next sample is accepted only after its last position is taken
// no-value samples give one result in the next cycle
// arst_n clears control state and the configuration registers to their reset values
`default_nettype none
module hashed_scalar_sparse_encoder
	import hsse_pkg::*;
#(
	parameter int unsigned MAX_ACTIVE = MaxActiveDef,
	parameter int unsigned MAX_SIZE   = MaxSizeDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	hsse_in_if.sink          in_ch,
	hsse_out_if.source       out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	logic [31:0] res_q, seed_q;
	logic [6:0]  act_q;
	logic [16:0] size_q, size_eff;
	hsse_op_t op;
	logic [2:0] hstep;
	logic [5:0] offset;
	logic pv, last;
	logic [31:0] sample_q;

	assign pready = 1'b1;
	// configuration writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= ResReset; act_q <= ActReset; size_q <= SizeReset; seed_q <= SeedReset;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				RegRes:  res_q <= pwdata;
				RegAct:  act_q <= pwdata[6:0];
				RegSize: size_q <= pwdata[16:0];
				RegSeed: seed_q <= pwdata;
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[3:2])
			RegRes:  prdata = res_q;
			RegAct:  prdata = {25'd0, act_q};
			RegSize: prdata = {15'd0, size_q};
			RegSeed: prdata = seed_q;
			default: prdata = 32'd0;
		endcase
	end
	always_comb begin
		size_eff = size_q;
		if (size_eff == 17'd0) size_eff = 17'd1;
		if (size_eff > 17'(MAX_SIZE)) size_eff = 17'(MAX_SIZE);
	end

	// sample held while the divider runs
	always_ff @(posedge clk)
		if (in_ch.valid && in_ch.ready) sample_q <= in_ch.sample;

	hsse_ctrl #(.MAX_ACTIVE(MAX_ACTIVE)) u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_no_value(in_ch.no_value), .in_ready(in_ch.ready),
		.out_ready(out_ch.ready), .out_valid(out_ch.valid),
		.out_pvalid(pv), .out_last(last),
		.active_bits(act_q), .op, .hstep, .offset
	);

	logic [15:0] pos;
	hsse_datapath u_dp (
		.clk, .op, .hstep,
		.sample(op == OP_DIV_START ? in_ch.sample : sample_q),
		.resolution(res_q), .size(size_eff), .seed_in(seed_q),
		.offset, .position(pos)
	);

	assign out_ch.bit_position   = pv ? pos : 16'd0;
	assign out_ch.position_valid = pv;
	assign out_ch.last_position  = last;
endmodule
`default_nettype wire

[tb/sv/tb_hashed_scalar_sparse_encoder.sv]
`timescale 1ns / 1ps
// self-checking bench for hashed_scalar_sparse_encoder: directed corners then random samples
// predicts every bit position in-bench from the register shadow and checks each output transaction
// depends on hsse_pkg, hsse_if and the encoder rtl
module tb_hashed_scalar_sparse_encoder;
	import hsse_pkg::*;

	// one expected output transaction
	typedef struct {
		logic [15:0] bit_position;
		logic        position_valid;
		logic        last_position;
	} position_t;

	localparam int unsigned StallLimit = 20000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	hsse_in_if  in_ch ();
	hsse_out_if out_ch ();

	hashed_scalar_sparse_encoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch.sink),
		.out_ch  (out_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow copy of the encoder registers
	logic [31:0] shadow_res;
	logic [6:0]  shadow_act;
	logic [16:0] shadow_size;
	logic [31:0] shadow_seed;

	position_t   expected_positions[$];
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned samples_sent;
	int unsigned positions_checked;
	int unsigned error_count;
	int unsigned quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// murmur3 x86_32 of one 4-byte word
	function automatic logic [31:0] murmur_word(logic [31:0] key, logic [31:0] seed);
		logic [31:0] h;
		logic [31:0] k;
		k = key * MurC1;
		k = {k[16:0], k[31:17]};
		k = k * MurC2;
		h = seed ^ k;
		h = {h[18:0], h[31:19]};
		h = h * 32'd5 + MurN;
		h = h ^ 32'd4;
		h = h ^ (h >> 16);
		h = h * MurF1;
		h = h ^ (h >> 13);
		h = h * MurF2;
		h = h ^ (h >> 16);
		return h;
	endfunction

	// queue every position that one accepted sample should produce
	function automatic void predict_positions(logic signed [31:0] sample, logic no_value);
		longint      num;
		longint      den;
		logic [63:0] quot;
		logic [31:0] bucket;
		logic [31:0] derived_seed;
		logic [31:0] h;
		int unsigned count;
		int unsigned size;
		position_t   p;
		if (no_value) begin
			p.bit_position = '0;
			p.position_valid = 1'b0;
			p.last_position = 1'b1;
			expected_positions.push_back(p);
			return;
		end
		num = longint'(sample);
		// zero width behaves as width one
		den = (shadow_res == 0) ? 64'sd1 : longint'({32'd0, shadow_res});
		quot = num / den;
		bucket = quot[31:0];
		count = (shadow_act == 0) ? 1 : shadow_act;
		if (count > MaxActiveDef) count = MaxActiveDef;
		size = (shadow_size == 0) ? 1 : shadow_size;
		if (size > MaxSizeDef) size = MaxSizeDef;
		derived_seed = murmur_word(shadow_seed, 32'd0);
		for (int unsigned k = 0; k < count; k++) begin
			h = murmur_word(bucket + k, derived_seed);
			p.bit_position = 16'(h % size);
			p.position_valid = 1'b1;
			p.last_position = (k + 1 == count);
			expected_positions.push_back(p);
		end
	endfunction

	// receiver: random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// compare each output transaction against the oldest prediction
	always @(posedge clk) begin
		position_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_positions.size() == 0) begin
				$display("%0t: unexpected position got pos=%0d valid=%0b last=%0b", $time,
					out_ch.bit_position, out_ch.position_valid, out_ch.last_position);
				error_count++;
			end else begin
				want = expected_positions.pop_front();
				positions_checked++;
				if (out_ch.bit_position !== want.bit_position) begin
					$display("%0t: bit_position expected %0d actual %0d", $time,
						want.bit_position, out_ch.bit_position);
					error_count++;
				end
				if (out_ch.position_valid !== want.position_valid) begin
					$display("%0t: position_valid expected %0b actual %0b", $time,
						want.position_valid, out_ch.position_valid);
					error_count++;
				end
				if (out_ch.last_position !== want.last_position) begin
					$display("%0t: last_position expected %0b actual %0b", $time,
						want.last_position, out_ch.last_position);
					error_count++;
				end
			end
		end
	end

	// watchdog: any handshake or register access counts as progress
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= StallLimit) begin
				$display("watchdog expired at %0t with %0d positions pending", $time,
					expected_positions.size());
				$display("tb_hashed_scalar_sparse_encoder: FAIL");
				$finish;
			end
		end
	end

	// one apb write: setup then access, shadow updated with it
	task automatic write_register(logic [1:0] reg_index, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (reg_index)
			RegRes:  shadow_res  = value;
			RegAct:  shadow_act  = value[6:0];
			RegSize: shadow_size = value[16:0];
			RegSeed: shadow_seed = value;
			default: ;
		endcase
	endtask

	// hand one sample over; valid stays high afterwards so back-to-back sends need no toggle
	task automatic send_sample(logic signed [31:0] sample, logic no_value);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 8) gap++;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.sample   <= sample;
		in_ch.no_value <= no_value;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_positions(sample, no_value);
		samples_sent++;
	endtask

	// stop sending and wait for every predicted position to come out
	task automatic drain_positions();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_positions.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// register values after reset, plus sign and range extremes of the sample
	task automatic test_reset_values();
		send_sample(32'sd0, 1'b0);
		send_sample(32'sd65536, 1'b0);
		send_sample(-32'sd65536, 1'b0);
		send_sample(32'h7fffffff, 1'b0);
		send_sample(32'h80000000, 1'b0);
		// absent sample, random payload ignored
		send_sample($urandom, 1'b1);
		send_sample(-32'sd1, 1'b0);
		drain_positions();
	endtask

	// register corners: zero, saturating and full-range values
	task automatic test_register_corners();
		write_register(RegRes, 32'd0);     // zero width acts as one
		write_register(RegAct, 32'd0);     // zero count acts as one
		send_sample(-32'sd1, 1'b0);
		send_sample(32'h80000000, 1'b0);
		drain_positions();
		write_register(RegRes, 32'hffffffff);
		write_register(RegAct, 32'd127);   // saturates to the maximum count
		write_register(RegSize, 32'd0);    // every position lands on zero
		send_sample(32'h7fffffff, 1'b0);
		drain_positions();
		write_register(RegRes, 32'd1);
		write_register(RegAct, 32'd64);
		write_register(RegSize, 32'h1ffff); // saturates to the maximum size
		write_register(RegSeed, 32'hffffffff);
		// bucket ffffffff: index+offset wraps past zero
		send_sample(-32'sd1, 1'b0);
		send_sample($urandom, 1'b1);
		drain_positions();
		write_register(RegAct, 32'd5);
		write_register(RegSize, 32'd65536);
		write_register(RegSeed, 32'd0);
		send_sample(32'sd12345, 1'b0);
		drain_positions();
		write_register(RegAct, 32'd3);
		write_register(RegSize, 32'd1);
		write_register(RegRes, 32'd65536);
		send_sample(32'sd3, 1'b0);
		drain_positions();
	endtask

	// random register setting for one segment; count mostly small to keep the run short
	task automatic randomize_registers();
		int unsigned pick;
		pick = $urandom_range(9);
		write_register(RegRes, (pick == 0) ? 32'd0 : (pick == 1) ? 32'hffffffff :
			(pick < 5) ? $urandom : $urandom_range(1, 32'h00080000));
		pick = $urandom_range(9);
		write_register(RegAct, (pick == 0) ? 32'd64 : (pick == 1) ? $urandom_range(65, 127) :
			$urandom_range(0, 8));
		pick = $urandom_range(9);
		write_register(RegSize, (pick == 0) ? 32'd65536 : (pick == 1) ? 32'd1 :
			(pick == 2) ? $urandom_range(65537, 131071) : $urandom_range(0, 65536));
		write_register(RegSeed, $urandom);
	endtask

	// random samples: wide random words, values near zero and near bucket edges, some absent
	task automatic test_random_samples(int unsigned n_samples);
		int unsigned pick;
		logic signed [31:0] sample;
		for (int unsigned i = 0; i < n_samples; i++) begin
			pick = $urandom_range(9);
			if (pick < 4) sample = $urandom;
			else if (pick < 7) sample = $signed($urandom_range(0, 600000)) - 32'sd300000;
			else if (pick < 9) sample = $signed(shadow_res) * $signed($urandom_range(0, 6) - 3);
			else sample = $urandom_range(1) ? 32'h80000000 : 32'h7fffffff;
			send_sample(sample, $urandom_range(7) == 0);
			// let the pipe empty completely once, halfway through
			if (i == n_samples / 2) drain_positions();
		end
		drain_positions();
	endtask

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		in_ch.valid    = 1'b0;
		in_ch.sample   = '0;
		in_ch.no_value = 1'b0;
		shadow_res     = ResReset;
		shadow_act     = ActReset;
		shadow_size    = SizeReset;
		shadow_seed    = SeedReset;
		send_idle_pct  = 0;
		recv_idle_pct  = 0;
		samples_sent      = 0;
		positions_checked = 0;
		error_count       = 0;
		quiet_cycles      = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 20;
		recv_idle_pct = 59;
		test_reset_values();
		test_register_corners();
		// three idle profiles, three register settings each
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 59 : 0;
			recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 20 : 0;
			for (int seg = 0; seg < 3; seg++) begin
				randomize_registers();
				test_random_samples(20);
			end
		end

		repeat (100) @(posedge clk);
		$display("covered %0d samples and %0d positions over corner and random settings",
			samples_sent, positions_checked);
		$display("mismatches: %0d, positions still pending: %0d", error_count,
			expected_positions.size());
		if (error_count == 0 && expected_positions.size() == 0) begin
			$display("tb_hashed_scalar_sparse_encoder: PASS");
		end else begin
			$display("tb_hashed_scalar_sparse_encoder: FAIL");
		end
		$finish;
	end
endmodule
